/* rtl/core/imad_pkg.sv */
// shared constants, payload types and control structs of the mean absolute difference block
package imad_pkg;

    // image and arithmetic sizes
    localparam int MAX_WIDTH     = 4096;
    localparam int MAX_HEIGHT    = 4096;
    localparam int FRACTION_BITS = 16;
    localparam int CHANNEL_SPAN  = 255 * 3;
    localparam int NUM_LANES     = 3;

    localparam int CHAN_W  = 8;
    localparam int DIM_W   = 13;
    localparam int SUM_W   = 10;
    localparam int COUNT_W = 24;
    localparam int PIX_W   = COUNT_W + 1;
    localparam int FRAME_W = 2 * DIM_W;
    localparam int TOTAL_W = 34;
    localparam int DEN_W   = 34;
    localparam int REM_W   = DEN_W + 1;
    localparam int MEAN_W  = 17;
    localparam int STEP_W  = $clog2(FRACTION_BITS + 1);

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_HEIGHT = 2'd3;

    // reset values of the dimension registers
    localparam logic [DIM_W-1:0] RESET_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0] RESET_HEIGHT = 13'd480;

    // result of a frame whose image sizes differ
    localparam logic [MEAN_W-1:0] MEAN_ONE = MEAN_W'(1) << FRACTION_BITS;

    typedef logic [CHAN_W-1:0] t_chan;

    typedef struct packed {
        t_chan a_blue;
        t_chan a_green;
        t_chan a_red;
        t_chan b_blue;
        t_chan b_green;
        t_chan b_red;
    } t_pixel;

    typedef struct packed {
        logic [MEAN_W-1:0] mean_difference;
        logic              size_mismatch;
    } t_result;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [DIM_W-1:0]     data;
    } t_cfg;

    // pixel travelling through the lane stage
    typedef struct packed {
        logic             valid;
        logic             last;
        logic             mismatch;
        logic [PIX_W-1:0] pixels;
    } t_s1;

    // frame end handed from the merge stage to the divider
    typedef struct packed {
        logic               start;
        logic [TOTAL_W-1:0] total;
        logic [PIX_W-1:0]   pixels;
        logic               mismatch;
    } t_div_req;

    typedef struct packed {
        logic              valid;
        logic [MEAN_W-1:0] mean;
        logic              mismatch;
    } t_div_rsp;

    // clamp a dimension register to 1..hi
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

/* rtl/core/imad_ifs.sv */
// valid/ready channel interfaces for pixels, results and configuration writes
interface imad_pix_if;
    logic               valid;
    logic               ready;
    imad_pkg::t_pixel   data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface imad_res_if;
    logic               valid;
    logic               ready;
    imad_pkg::t_result  data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface imad_cfg_if;
    logic               valid;
    logic               ready;
    imad_pkg::t_cfg     data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

/* rtl/core/image_mean_abs_difference_top.sv */
// top level of the mean absolute difference block: config, lanes, merge, divider, output
//
//  channel  dir  transaction           payload
//  i_pix    in   one pixel pair        a_/b_ blue, green, red (8 bits each)
//  i_cfg    in   register write        index 0..3, 13-bit dimension
//  o_res    out  one result per frame  mean_difference (17), size_mismatch (1)
//
//  pixels are taken one per cycle while i_pix.ready is high; the three channel lanes register the differences,
//  the merge stage adds them into the frame total in the next cycle.
//  at frame end i_pix.ready drops until the output register takes the result: a 765 * pixels multiply and
//  17 quotient bits of the divider, plus hand-off; a size mismatch skips the divide.
//  a waiting result sits in the output register while the next frame streams in.
//  synchronous active-low reset restores 640 x 480 for both images and clears the counters, total and valid flags.
module image_mean_abs_difference_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    imad_pix_if.sink      i_pix,
    imad_cfg_if.sink      i_cfg,
    imad_res_if.source    o_res
);

    // dimension registers, kept clamped, with derived frame size and mismatch
    logic [imad_pkg::DIM_W-1:0]   r_w1, r_h1, r_w2, r_h2;
    logic [imad_pkg::DIM_W-1:0]   n_w1, n_h1, n_w2, n_h2;
    logic [imad_pkg::FRAME_W-1:0] r_frame;
    logic                         r_mismatch;
    logic [imad_pkg::DIM_W-1:0]   w_cfg_dim_w, w_cfg_dim_h;
    logic                         w_cfg_wr;

    assign i_cfg.ready = 1'b1;
    assign w_cfg_wr    = i_cfg.valid;
    assign w_cfg_dim_w = imad_pkg::clamp_dim(i_cfg.data.data,
                                             imad_pkg::DIM_W'(imad_pkg::MAX_WIDTH));
    assign w_cfg_dim_h = imad_pkg::clamp_dim(i_cfg.data.data,
                                             imad_pkg::DIM_W'(imad_pkg::MAX_HEIGHT));

    // next register values for a configuration transaction
    always_comb begin
        n_w1 = r_w1;
        n_h1 = r_h1;
        n_w2 = r_w2;
        n_h2 = r_h2;
        unique case (i_cfg.data.index)
            imad_pkg::REG_FIRST_WIDTH:   n_w1 = w_cfg_dim_w;
            imad_pkg::REG_FIRST_HEIGHT:  n_h1 = w_cfg_dim_h;
            imad_pkg::REG_SECOND_WIDTH:  n_w2 = w_cfg_dim_w;
            imad_pkg::REG_SECOND_HEIGHT: n_h2 = w_cfg_dim_h;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w1       <= imad_pkg::RESET_WIDTH;
            r_h1       <= imad_pkg::RESET_HEIGHT;
            r_w2       <= imad_pkg::RESET_WIDTH;
            r_h2       <= imad_pkg::RESET_HEIGHT;
            r_frame    <= imad_pkg::FRAME_W'(imad_pkg::RESET_WIDTH)
                        * imad_pkg::FRAME_W'(imad_pkg::RESET_HEIGHT);
            r_mismatch <= 1'b0;
        end else if (w_cfg_wr) begin
            r_w1       <= n_w1;
            r_h1       <= n_h1;
            r_w2       <= n_w2;
            r_h2       <= n_h2;
            r_frame    <= imad_pkg::FRAME_W'(n_w1) * imad_pkg::FRAME_W'(n_h1);
            r_mismatch <= (n_w1 != n_w2) || (n_h1 != n_h2);
        end
    end

    // pixel count and frame end detection
    logic                           r_busy;
    logic [imad_pkg::COUNT_W-1:0]   r_count;
    logic [imad_pkg::PIX_W-1:0]     w_pixels;
    logic                           w_last;
    logic                           w_accept;
    logic                           w_take;

    assign i_pix.ready = !r_busy;
    assign w_accept    = i_pix.valid && i_pix.ready;
    assign w_pixels    = imad_pkg::PIX_W'(r_count) + imad_pkg::PIX_W'(1);
    assign w_last      = (imad_pkg::FRAME_W'(w_pixels) >= r_frame);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_busy  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= w_last ? '0 : w_pixels[imad_pkg::COUNT_W-1:0];
            end
            if (w_take) begin
                r_busy <= 1'b0;
            end else if (w_accept && w_last) begin
                r_busy <= 1'b1;
            end
        end
    end

    // lane stage side information
    imad_pkg::t_s1 r_s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else begin
            r_s1.valid    <= w_accept;
            r_s1.last     <= w_last;
            r_s1.mismatch <= r_mismatch;
            r_s1.pixels   <= w_pixels;
        end
    end

    // channel lanes
    imad_pkg::t_chan [imad_pkg::NUM_LANES-1:0] w_diff;

    imad_lane u_lane_blue (
        .i_clk  (i_clk),
        .i_en   (w_accept),
        .i_a    (i_pix.data.a_blue),
        .i_b    (i_pix.data.b_blue),
        .o_diff (w_diff[0])
    );

    imad_lane u_lane_green (
        .i_clk  (i_clk),
        .i_en   (w_accept),
        .i_a    (i_pix.data.a_green),
        .i_b    (i_pix.data.b_green),
        .o_diff (w_diff[1])
    );

    imad_lane u_lane_red (
        .i_clk  (i_clk),
        .i_en   (w_accept),
        .i_a    (i_pix.data.a_red),
        .i_b    (i_pix.data.b_red),
        .o_diff (w_diff[2])
    );

    // merge and divide
    imad_pkg::t_div_req w_req;
    imad_pkg::t_div_rsp w_rsp;

    imad_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s1    (r_s1),
        .i_diff  (w_diff),
        .o_req   (w_req)
    );

    imad_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_take  (w_take),
        .o_rsp   (w_rsp)
    );

    // output register
    logic               r_out_valid;
    imad_pkg::t_result  r_out;

    assign w_take = w_rsp.valid && (!r_out_valid || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out.mean_difference <= w_rsp.mean;
            r_out.size_mismatch   <= w_rsp.mismatch;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

endmodule

/* rtl/core/imad_lane.sv */
// one channel lane: registered absolute difference of two 8-bit samples
module imad_lane (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  imad_pkg::t_chan       i_a,
    input  imad_pkg::t_chan       i_b,
    output imad_pkg::t_chan       o_diff
);

    imad_pkg::t_chan r_diff;
    imad_pkg::t_chan n_diff;

    // absolute difference
    always_comb begin
        if (i_a > i_b) begin
            n_diff = i_a - i_b;
        end else begin
            n_diff = i_b - i_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_diff <= n_diff;
        end
    end

    assign o_diff = r_diff;

endmodule

/* rtl/core/imad_merge.sv */
// merge stage: adds the lane differences into the frame total and hands frame ends on
module imad_merge (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  imad_pkg::t_s1                                i_s1,
    input  imad_pkg::t_chan [imad_pkg::NUM_LANES-1:0]    i_diff,
    output imad_pkg::t_div_req                           o_req
);

    logic [imad_pkg::TOTAL_W-1:0] r_total;
    logic [imad_pkg::TOTAL_W-1:0] n_total;
    logic [imad_pkg::SUM_W-1:0]   w_sum;

    // combine the lanes, pixels seen under a size mismatch add nothing
    always_comb begin
        w_sum = '0;
        for (int i = 0; i < imad_pkg::NUM_LANES; i++) begin
            w_sum = w_sum + imad_pkg::SUM_W'(i_diff[i]);
        end
        if (i_s1.mismatch) begin
            n_total = r_total;
        end else begin
            n_total = r_total + imad_pkg::TOTAL_W'(w_sum);
        end
    end

    // running total, cleared at frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (i_s1.valid) begin
            if (i_s1.last) begin
                r_total <= '0;
            end else begin
                r_total <= n_total;
            end
        end
    end

    assign o_req.start    = i_s1.valid && i_s1.last;
    assign o_req.total    = n_total;
    assign o_req.pixels   = i_s1.pixels;
    assign o_req.mismatch = i_s1.mismatch;

endmodule

/* rtl/core/imad_div.sv */
// frame divider: total * 2^FRACTION_BITS / (765 * pixels), one quotient bit per cycle
module imad_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  imad_pkg::t_div_req    i_req,
    input  logic                  i_take,
    output imad_pkg::t_div_rsp    o_rsp
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]                    r_state;
    logic [imad_pkg::TOTAL_W-1:0]  r_total;
    logic [imad_pkg::PIX_W-1:0]    r_pix;
    logic                          r_mis;
    logic [imad_pkg::DEN_W-1:0]    r_den;
    logic [imad_pkg::REM_W-1:0]    r_rem;
    logic [imad_pkg::MEAN_W-1:0]   r_q;
    logic [imad_pkg::STEP_W-1:0]   r_step;

    logic                          w_bit;
    logic [imad_pkg::REM_W-1:0]    w_trial;
    logic [imad_pkg::REM_W-1:0]    w_den;
    logic                          w_ge;

    // restoring division step; only the lowest total bit enters below the start remainder
    always_comb begin
        w_bit   = (r_step == imad_pkg::STEP_W'(imad_pkg::FRACTION_BITS)) ? r_total[0] : 1'b0;
        w_trial = {r_rem[imad_pkg::REM_W-2:0], w_bit};
        w_den   = imad_pkg::REM_W'(r_den);
        w_ge    = (w_trial >= w_den);
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_req.start) begin
                        r_state <= i_req.mismatch ? ST_DONE : ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_state <= ST_RUN;
                end
                ST_RUN: begin
                    if (r_step == '0) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (i_take) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (i_req.start) begin
                    r_total <= i_req.total;
                    r_pix   <= i_req.pixels;
                    r_mis   <= i_req.mismatch;
                    r_rem   <= imad_pkg::REM_W'(i_req.total >> 1);
                    r_step  <= imad_pkg::STEP_W'(imad_pkg::FRACTION_BITS);
                    r_q     <= imad_pkg::MEAN_ONE;
                end
            end
            ST_MUL: begin
                r_den <= imad_pkg::DEN_W'(imad_pkg::CHANNEL_SPAN) * imad_pkg::DEN_W'(r_pix);
            end
            ST_RUN: begin
                r_rem  <= w_ge ? (w_trial - w_den) : w_trial;
                r_q    <= {r_q[imad_pkg::MEAN_W-2:0], w_ge};
                r_step <= r_step - imad_pkg::STEP_W'(1);
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    assign o_rsp.valid    = (r_state == ST_DONE);
    assign o_rsp.mean     = r_q;
    assign o_rsp.mismatch = r_mis;

endmodule

/* rtl/core/imad_check.sv */
// port checker for the mean absolute difference block, bound to the top level
module imad_check (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_res_valid,
    input  logic                           i_res_ready,
    input  logic [imad_pkg::MEAN_W-1:0]    i_res_mean,
    input  logic                           i_res_mismatch,
    input  logic                           i_pix_ready
);

    // a stalled result stays offered
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_res_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> $stable(i_res_mean) && $stable(i_res_mismatch))
        else $error("result payload changed while stalled");

    // a size mismatch reports exactly 1.0
    a_mismatch_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_mismatch |-> i_res_mean == imad_pkg::MEAN_ONE)
        else $error("mismatch result is not 1.0");

    // the mean never exceeds 1.0
    a_mean_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_res_mean <= imad_pkg::MEAN_ONE)
        else $error("mean above 1.0");

    // a new result only appears after the pixel side has been held off
    a_result_after_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_res_valid) |-> $past(!i_pix_ready))
        else $error("result without frame end");

endmodule

bind image_mean_abs_difference_top imad_check u_imad_check (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_res_mean     (o_res.data.mean_difference),
    .i_res_mismatch (o_res.data.size_mismatch),
    .i_pix_ready    (i_pix.ready)
);

/* sim/image_mean_abs_difference_checker.sv */
// checker for the mean absolute difference block: frame mean predictor and result compare
module image_mean_abs_difference_checker
    import imad_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    imad_pix_if   i_pix,
    imad_cfg_if   i_cfg,
    imad_res_if   i_res,
    output int    o_fail_count,
    output int    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow copy of the dimension registers
    logic [DIM_W-1:0]   first_w;
    logic [DIM_W-1:0]   first_h;
    logic [DIM_W-1:0]   second_w;
    logic [DIM_W-1:0]   second_h;

    // running frame state
    logic [TOTAL_W-1:0] diff_sum;
    logic [COUNT_W-1:0] pix_seen;

    // frame means still owed by the block, oldest first
    t_result            mean_queue[$];
    int                 fail_total = 0;

    assign o_fail_count = fail_total;

    task automatic report_mismatch(input string msg);
        $display("checker: %s", msg);
        fail_total++;
    endtask

    // zero counts as one, anything above the limit is cut to the limit
    function automatic logic [DIM_W-1:0] fit_dim(input logic [DIM_W-1:0] v, input int hi);
        if (v == '0) begin
            return DIM_W'(1);
        end
        if (int'(v) > hi) begin
            return DIM_W'(hi);
        end
        return v;
    endfunction

    function automatic logic [TOTAL_W-1:0] chan_gap(input t_chan x, input t_chan y);
        return (x > y) ? TOTAL_W'(x - y) : TOTAL_W'(y - x);
    endfunction

    // add one pixel pair to the frame, queue the mean when the frame closes
    task automatic fold_pixel(input t_pixel px);
        logic [DIM_W-1:0]   w1;
        logic [DIM_W-1:0]   h1;
        logic [DIM_W-1:0]   w2;
        logic [DIM_W-1:0]   h2;
        logic [FRAME_W-1:0] frame;
        logic [PIX_W-1:0]   pixels;
        logic [63:0]        num;
        logic [63:0]        den;
        logic               differ;
        t_result            r;
        w1 = fit_dim(first_w, MAX_WIDTH);
        h1 = fit_dim(first_h, MAX_HEIGHT);
        w2 = fit_dim(second_w, MAX_WIDTH);
        h2 = fit_dim(second_h, MAX_HEIGHT);
        differ = (w1 != w2) || (h1 != h2);
        frame = w1 * h1;
        // pixels under a size mismatch are counted but not summed
        if (!differ) begin
            diff_sum = diff_sum + chan_gap(px.a_blue, px.b_blue)
                     + chan_gap(px.a_green, px.b_green)
                     + chan_gap(px.a_red, px.b_red);
        end
        pixels = PIX_W'(pix_seen) + PIX_W'(1);
        if (pixels < frame) begin
            pix_seen = pixels[COUNT_W-1:0];
        end else begin
            // frame closes, divisor is the pixels actually counted
            if (differ) begin
                r.mean_difference = MEAN_W'(64'd1 << FRACTION_BITS);
                r.size_mismatch   = 1'b1;
            end else begin
                num = 64'(diff_sum) << FRACTION_BITS;
                den = 64'(CHANNEL_SPAN) * 64'(pixels);
                r.mean_difference = MEAN_W'(num / den);
                r.size_mismatch   = 1'b0;
            end
            mean_queue = {mean_queue, r};
            diff_sum = '0;
            pix_seen = '0;
        end
    endtask

    // watch all three channels at each edge
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            first_w  = RESET_WIDTH;
            first_h  = RESET_HEIGHT;
            second_w = RESET_WIDTH;
            second_h = RESET_HEIGHT;
            diff_sum = '0;
            pix_seen = '0;
            mean_queue.delete();
        end else begin
            // delivered result against the oldest prediction
            if (i_res.valid && i_res.ready) begin
                if (mean_queue.size() == 0) begin
                    report_mismatch($sformatf("unexpected result mean %0d flag %0b",
                                              i_res.data.mean_difference,
                                              i_res.data.size_mismatch));
                end else begin
                    want = mean_queue.pop_front();
                    if (i_res.data.mean_difference !== want.mean_difference) begin
                        report_mismatch($sformatf("mean_difference %0d, predicted %0d",
                                                  i_res.data.mean_difference,
                                                  want.mean_difference));
                    end
                    if (i_res.data.size_mismatch !== want.size_mismatch) begin
                        report_mismatch($sformatf("size_mismatch %0b, predicted %0b",
                                                  i_res.data.size_mismatch,
                                                  want.size_mismatch));
                    end
                end
            end
            // register write transaction
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.data.index)
                    REG_FIRST_WIDTH:   first_w  = i_cfg.data.data;
                    REG_FIRST_HEIGHT:  first_h  = i_cfg.data.data;
                    REG_SECOND_WIDTH:  second_w = i_cfg.data.data;
                    REG_SECOND_HEIGHT: second_h = i_cfg.data.data;
                    default: ;
                endcase
            end
            // pixel pair transaction
            if (i_pix.valid && i_pix.ready) begin
                fold_pixel(i_pix.data);
            end
        end
        o_pending <= mean_queue.size();
    end

endmodule

/* sim/image_mean_abs_difference_top_tb.sv */
// testbench top for the mean absolute difference block: clock, reset, stimulus and verdict
module image_mean_abs_difference_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import imad_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 1500;

    localparam t_chan            FULL         = 8'hFF;
    localparam t_chan            ZERO         = 8'h00;
    localparam logic [DIM_W-1:0] DIM_ALL_ONES = '1;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_LIGHT} t_rx_mode;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    int        fail_count;
    int        pending_results;
    int        cycle_count = 0;
    int        burst_left = 0;
    bit        quiet_sender = 1'b0;
    int        random_items = 0;
    logic [5:0] stall_phase = '0;
    t_rx_mode  stall_mode = RX_OPEN;

    imad_pix_if pix_ch();
    imad_cfg_if cfg_ch();
    imad_res_if res_ch();

    image_mean_abs_difference_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    image_mean_abs_difference_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (pix_ch),
        .i_cfg        (cfg_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side stalls, mode picked each time the stall phase counter wraps
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1'b1;
        if (stall_phase == '0) begin
            stall_mode <= t_rx_mode'($urandom_range(0, 3));
        end
        case (stall_mode)
            RX_OPEN:   res_ch.ready <= 1'b1;
            RX_COIN:   res_ch.ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: res_ch.ready <= (stall_phase[2:0] == 3'd0);
            default:   res_ch.ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    function automatic t_pixel make_pixel(input t_chan ab, input t_chan ag, input t_chan ar,
                                          input t_chan bb, input t_chan bg, input t_chan br);
        t_pixel px;
        px.a_blue  = ab;
        px.a_green = ag;
        px.a_red   = ar;
        px.b_blue  = bb;
        px.b_green = bg;
        px.b_red   = br;
        return px;
    endfunction

    function automatic t_chan random_chan(input bit rail);
        if (rail) begin
            return $urandom_range(0, 1) ? FULL : ZERO;
        end
        return t_chan'($urandom_range(0, 255));
    endfunction

    // uniform pairs mostly, some at the rails, some identical
    function automatic t_pixel random_pixel();
        t_pixel px;
        int     kind;
        bit     rail;
        kind = $urandom_range(0, 9);
        rail = (kind < 2);
        px = make_pixel(random_chan(rail), random_chan(rail), random_chan(rail),
                        random_chan(rail), random_chan(rail), random_chan(rail));
        if (kind == 2) begin
            px.b_blue  = px.a_blue;
            px.b_green = px.a_green;
            px.b_red   = px.a_red;
        end
        return px;
    endfunction

    // dimension for a small frame, now and then zero
    function automatic logic [DIM_W-1:0] small_dim(input int hi);
        if ($urandom_range(0, 7) == 0) begin
            return '0;
        end
        return DIM_W'($urandom_range(1, hi));
    endfunction

    // one pixel transaction, sender idles between bursts
    task automatic push_pixel(input t_pixel px);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = quiet_sender ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                pix_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        pix_ch.valid <= 1'b1;
        pix_ch.data  <= px;
        do @(posedge i_clk); while (!pix_ch.ready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= '{index: idx, data: val};
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic set_dims(input logic [DIM_W-1:0] fw, input logic [DIM_W-1:0] fh,
                            input logic [DIM_W-1:0] sw, input logic [DIM_W-1:0] sh);
        write_reg(REG_FIRST_WIDTH, fw);
        write_reg(REG_FIRST_HEIGHT, fh);
        write_reg(REG_SECOND_WIDTH, sw);
        write_reg(REG_SECOND_HEIGHT, sh);
        cfg_ch.valid <= 1'b0;
    endtask

    // stop sending, wait for owed results and let the divider drain
    task automatic settle();
        pix_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // small frame with random sizes, often stopped mid-frame
    task automatic random_phase();
        logic [DIM_W-1:0] fw;
        logic [DIM_W-1:0] fh;
        logic [DIM_W-1:0] sw;
        logic [DIM_W-1:0] sh;
        int               frame;
        int               n;
        fw = small_dim(6);
        fh = small_dim(4);
        sw = fw;
        sh = fh;
        case ($urandom_range(0, 9))
            0: sw = DIM_W'($urandom);
            1: sh = DIM_W'($urandom);
            2: sh = small_dim(4);
            3: begin
                // zero and one clamp to the same size
                if (sw == '0) sw = DIM_W'(1); else if (sw == DIM_W'(1)) sw = '0;
                if (sh == '0) sh = DIM_W'(1); else if (sh == DIM_W'(1)) sh = '0;
            end
            default: ;
        endcase
        frame = ((fw == '0) ? 1 : int'(fw)) * ((fh == '0) ? 1 : int'(fh));
        n = $urandom_range(0, 1) ? frame * $urandom_range(1, 3) : $urandom_range(1, 3 * frame);
        quiet_sender = ($urandom_range(0, 3) == 0);
        set_dims(fw, fh, sw, sh);
        repeat (n) push_pixel(random_pixel());
        random_items += n;
        settle();
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        pix_ch.valid <= 1'b0;
        pix_ch.data  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // a few pixels under the reset sizes, frame stays open
        push_pixel(make_pixel(FULL, FULL, FULL, ZERO, ZERO, ZERO));
        push_pixel(make_pixel(ZERO, ZERO, ZERO, FULL, FULL, FULL));
        push_pixel(make_pixel(8'h55, 8'hAA, 8'h01, 8'h55, 8'hAA, 8'h01));
        settle();

        // shrink the frame below the count, then a full-scale difference
        set_dims(13'd2, 13'd1, 13'd2, 13'd1);
        push_pixel(make_pixel(8'h12, 8'h34, 8'h56, 8'h65, 8'h43, 8'h21));
        push_pixel(make_pixel(FULL, FULL, FULL, ZERO, ZERO, ZERO));
        push_pixel(make_pixel(ZERO, ZERO, ZERO, FULL, FULL, FULL));
        settle();

        // zero sizes clamp to one pixel, one channel at a time
        set_dims('0, 13'd1, 13'd1, '0);
        push_pixel(make_pixel(FULL, ZERO, ZERO, ZERO, ZERO, ZERO));
        push_pixel(make_pixel(ZERO, ZERO, ZERO, ZERO, FULL, ZERO));
        push_pixel(make_pixel(ZERO, ZERO, FULL, ZERO, ZERO, ZERO));
        push_pixel(make_pixel(FULL, FULL, FULL, FULL, FULL, FULL));
        settle();

        // width mismatch on single-pixel frames
        set_dims(13'd1, 13'd1, 13'd3, 13'd1);
        push_pixel(random_pixel());
        push_pixel(random_pixel());
        settle();

        // mismatch appears on the last pixel of a frame
        set_dims(13'd2, 13'd1, 13'd2, 13'd1);
        push_pixel(random_pixel());
        settle();
        set_dims(13'd2, 13'd1, 13'd2, 13'd4);
        push_pixel(random_pixel());
        settle();

        // mismatch early in a frame, sizes agree at the end
        set_dims(13'd1, 13'd2, 13'd2, 13'd2);
        push_pixel(random_pixel());
        settle();
        set_dims(13'd2, 13'd1, 13'd2, 13'd1);
        push_pixel(make_pixel(FULL, FULL, FULL, ZERO, ZERO, ZERO));
        settle();

        // frame shrinks after several pixels
        set_dims(13'd3, 13'd2, 13'd3, 13'd2);
        repeat (4) push_pixel(random_pixel());
        settle();
        set_dims(13'd1, 13'd2, 13'd1, 13'd2);
        push_pixel(random_pixel());
        settle();

        // oversized height clamps to the maximum, frame then cut short
        set_dims(13'd1, DIM_ALL_ONES, 13'd1, DIM_W'(MAX_HEIGHT));
        repeat (3) push_pixel(random_pixel());
        settle();
        set_dims(13'd1, 13'd3, 13'd1, 13'd3);
        push_pixel(random_pixel());
        settle();

        // widest clamped size, frame then cut short
        quiet_sender = 1'b0;
        set_dims(DIM_ALL_ONES, 13'd1, DIM_W'(MAX_WIDTH), '0);
        repeat (5) push_pixel(random_pixel());
        settle();
        set_dims(13'd1, 13'd1, 13'd1, 13'd1);
        push_pixel(random_pixel());
        settle();

        // random small frames
        while (random_items < RANDOM_ITEMS) begin
            random_phase();
        end
        settle();

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/imad_pkg.sv
rtl/core/imad_ifs.sv
rtl/core/imad_lane.sv
rtl/core/imad_merge.sv
rtl/core/imad_div.sv
rtl/core/image_mean_abs_difference_top.sv
rtl/core/imad_check.sv
sim/image_mean_abs_difference_checker.sv
sim/image_mean_abs_difference_top_tb.sv
